/* design/tumc_pkg.sv */
`default_nettype none

package tumc_pkg;

    localparam int TABLE_DEPTH_DEF = 65536;

    localparam int ENTRY_W   = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MARK  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_PORT = 1'd1;

    localparam logic [31:0] MIRROR_MARK_RST  = 32'd12131989;
    localparam logic [15:0] WATCHED_PORT_RST = 16'd5432;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] ETH_IP_BYTES   = 16'd34;
    localparam logic [16:0] ETH_IP_TCP_MIN = 17'd34;
    localparam logic [7:0]  UDP_HDR_BYTES  = 8'd8;
    localparam logic [16:0] PROTO_DELTA    = 17'd11;

    localparam logic       ACT_WRITE    = 1'b0;
    localparam logic       ACT_CLASSIFY = 1'b1;

    localparam logic [1:0] V_PASS    = 2'd0;
    localparam logic [1:0] V_DROP    = 2'd1;
    localparam logic [1:0] V_MIRROR  = 2'd2;
    localparam logic [1:0] V_WRITTEN = 2'd3;

    typedef struct packed {
        logic        action;
        logic [31:0] pkt_mark;
        logic [15:0] frame_len;
        logic [15:0] ethertype;
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_hdr_words;
        logic [15:0] ip_total_len;
        logic [15:0] server_port;
        logic [15:0] dest_port;
        logic [3:0]  tcp_hdr_words;
        logic [15:0] ip_checksum;
        logic [47:0] entry_value;
    } tumc_req_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] udp_dest_port;
        logic [15:0] udp_length;
        logic [7:0]  payload_offset;
        logic [31:0] tcp_port_tag;
        logic [15:0] new_ip_checksum;
    } tumc_rsp_t;

    function automatic logic [15:0] csum_update(input logic [15:0] old_sum);
        logic [16:0] acc;
        acc = {1'b0, ~old_sum} + PROTO_DELTA;
        acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
        acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
        return ~acc[15:0];
    endfunction

endpackage

`default_nettype wire

/* design/tcp_to_udp_mirror_classifier.sv */
// The table entry is registered at item accept; the verdict is registered into the result
// in the evaluation state when the output is free. req_ready is low until that state is left.
// Reset: rst_n asynchronous, active low; the port table is cleared by a pass over all
// TABLE_DEPTH entries after reset, during which req_ready stays low.
// Configuration writes are taken on any cycle, including during the clearing pass.
`default_nettype none

module tcp_to_udp_mirror_classifier #(
    parameter int TABLE_DEPTH = tumc_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   req_valid,
    output logic                                  req_ready,
    input  wire  tumc_pkg::tumc_req_t             req,
    output logic                                  rsp_valid,
    input  wire                                   rsp_ready,
    output tumc_pkg::tumc_rsp_t                   rsp,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [tumc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [tumc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tumc_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0]       mirror_mark_reg;
    logic [15:0]       watched_port_reg;

    logic [1:0]        pre_verdict_reg;
    logic              cand_reg;
    logic [15:0]       udp_len_reg;
    logic [7:0]        poff_reg;
    logic [15:0]       csum_reg;

    logic              out_valid_reg, out_valid_next;
    tumc_rsp_t         out_reg;
    tumc_rsp_t         out_next;

    logic              req_fire;
    logic              in_range;
    logic [ADDR_W-1:0] tbl_idx;
    logic [5:0]        ip_bytes;
    logic [5:0]        tcp_bytes;
    logic [1:0]        pre_verdict;
    logic              cand;
    logic              load_out;
    logic              entry_hit;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign tbl_idx   = req.server_port[ADDR_W-1:0];
    assign in_range  = {16'd0, req.server_port} < 32'(TABLE_DEPTH);
    assign ip_bytes  = {req.ip_hdr_words, 2'b00};
    assign tcp_bytes = {req.tcp_hdr_words, 2'b00};

    // classify everything that does not need the table
    always_comb
    begin
        pre_verdict = V_PASS;
        cand        = 1'b0;
        if (req.action == ACT_WRITE)
        begin
            pre_verdict = V_WRITTEN;
        end
        else if (req.pkt_mark == mirror_mark_reg)
        begin
            pre_verdict = V_PASS;
        end
        else if (req.frame_len < ETH_HDR_BYTES)
        begin
            pre_verdict = V_DROP;
        end
        else if (req.ethertype != ETHERTYPE_IPV4)
        begin
            pre_verdict = V_PASS;
        end
        else if (req.frame_len < ETH_IP_BYTES)
        begin
            pre_verdict = V_DROP;
        end
        else if (req.ip_protocol != PROTO_TCP)
        begin
            pre_verdict = V_PASS;
        end
        else if ((ETH_IP_TCP_MIN + {11'd0, ip_bytes}) > {1'b0, req.frame_len})
        begin
            pre_verdict = V_DROP;
        end
        else if (req.dest_port != watched_port_reg)
        begin
            pre_verdict = V_PASS;
        end
        else if (({10'd0, ip_bytes} + {10'd0, tcp_bytes}) == req.ip_total_len)
        begin
            pre_verdict = V_PASS;
        end
        else if (!in_range)
        begin
            pre_verdict = V_PASS;
        end
        else
        begin
            cand = 1'b1;
        end
    end

    // table write port: clearing pass, else write items
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            table_mem[clr_cnt_reg] <= '0;
        end
        else if (req_fire && req.action == ACT_WRITE && in_range)
        begin
            table_mem[tbl_idx] <= req.entry_value;
        end
    end

    // table read port
    always_ff @(posedge clk)
    begin
        if (req_fire && req.action == ACT_CLASSIFY && in_range)
        begin
            rd_data_reg <= table_mem[tbl_idx];
        end
    end

    // hold item results while the table is read
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pre_verdict_reg <= pre_verdict;
            cand_reg        <= cand;
            udp_len_reg     <= req.ip_total_len - {10'd0, ip_bytes};
            poff_reg        <= {2'b00, tcp_bytes} - UDP_HDR_BYTES;
            csum_reg        <= csum_update(req.ip_checksum);
        end
    end

    assign entry_hit = (rd_data_reg[15:0] != 16'd0);
    assign load_out  = (state_reg == ST_EVAL) && (!out_valid_reg || rsp_ready);

    always_comb
    begin
        out_next = '0;
        if (cand_reg && entry_hit)
        begin
            out_next.verdict         = V_MIRROR;
            out_next.udp_dest_port   = rd_data_reg[15:0];
            out_next.udp_length      = udp_len_reg;
            out_next.payload_offset  = poff_reg;
            out_next.tcp_port_tag    = rd_data_reg[47:16];
            out_next.new_ip_checksum = csum_reg;
        end
        else if (cand_reg)
        begin
            out_next.verdict = V_PASS;
        end
        else
        begin
            out_next.verdict = pre_verdict_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_mark_reg  <= MIRROR_MARK_RST;
            watched_port_reg <= WATCHED_PORT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIRROR_MARK:
                begin
                    mirror_mark_reg <= cfg_data;
                end
                CFG_WATCHED_PORT:
                begin
                    watched_port_reg <= cfg_data[15:0];
                end
                default:
                begin
                    mirror_mark_reg <= mirror_mark_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

    import tumc_pkg::*;

    localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
    localparam int TCP_MIN_BYTES = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    tumc_req_t req;
    logic rsp_valid;
    logic rsp_ready;
    tumc_rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [31:0] cur_mark;
    logic [15:0] cur_watch;
    logic [47:0] mirror_entries [int];
    logic [15:0] port_pool [8];
    tumc_rsp_t pending_results [$];
    bit steady;
    int fail_count;

    tcp_to_udp_mirror_classifier #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic tumc_rsp_t classify_item(input tumc_req_t item);
        tumc_rsp_t res;
        int ip_bytes;
        int tcp_bytes;
        logic [47:0] entry;
        logic [15:0] inv;
        logic [31:0] acc;
        res = '0;
        ip_bytes = 4 * int'(item.ip_hdr_words);
        tcp_bytes = 4 * int'(item.tcp_hdr_words);
        if (item.action == ACT_WRITE)
        begin
            if (int'(item.server_port) < TBL_DEPTH)
                mirror_entries[int'(item.server_port)] = item.entry_value;
            res.verdict = V_WRITTEN;
            return res;
        end
        entry = '0;
        if (int'(item.server_port) < TBL_DEPTH && mirror_entries.exists(int'(item.server_port)))
            entry = mirror_entries[int'(item.server_port)];
        if (item.pkt_mark == cur_mark)
            res.verdict = V_PASS;
        else if (item.frame_len < ETH_HDR_BYTES)
            res.verdict = V_DROP;
        else if (item.ethertype != ETHERTYPE_IPV4)
            res.verdict = V_PASS;
        else if (item.frame_len < ETH_IP_BYTES)
            res.verdict = V_DROP;
        else if (item.ip_protocol != PROTO_TCP)
            res.verdict = V_PASS;
        else if (int'(ETH_HDR_BYTES) + ip_bytes + TCP_MIN_BYTES > int'(item.frame_len))
            res.verdict = V_DROP;
        else if (item.dest_port != cur_watch)
            res.verdict = V_PASS;
        else if (ip_bytes + tcp_bytes == int'(item.ip_total_len))
            res.verdict = V_PASS;
        else if (int'(item.server_port) >= TBL_DEPTH || entry[15:0] == 16'd0)
            res.verdict = V_PASS;
        else
        begin
            res.verdict = V_MIRROR;
            res.udp_dest_port = entry[15:0];
            res.tcp_port_tag = entry[47:16];
            res.udp_length = item.ip_total_len - 16'(ip_bytes);
            res.payload_offset = 8'(tcp_bytes - 8);
            inv = ~item.ip_checksum;
            acc = 32'(inv) + 32'd11;
            acc = (acc & 32'hFFFF) + (acc >> 16);
            acc = (acc & 32'hFFFF) + (acc >> 16);
            res.new_ip_checksum = ~acc[15:0];
        end
        return res;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic tumc_req_t noise_item();
        logic [223:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(tumc_req_t)-1:0];
    endfunction

    function automatic tumc_req_t table_write(input logic [15:0] port, input logic [47:0] value);
        tumc_req_t item;
        item = noise_item();
        item.action = ACT_WRITE;
        item.server_port = port;
        item.entry_value = value;
        return item;
    endfunction

    function automatic tumc_req_t mirror_candidate(input logic [15:0] port);
        tumc_req_t item;
        item = noise_item();
        item.action = ACT_CLASSIFY;
        if (item.pkt_mark == cur_mark)
            item.pkt_mark = cur_mark + 32'd1;
        item.ethertype = ETHERTYPE_IPV4;
        item.ip_protocol = PROTO_TCP;
        item.ip_hdr_words = 4'd5;
        item.tcp_hdr_words = 4'd5;
        item.ip_total_len = 16'd1500;
        item.frame_len = 16'd1514;
        item.server_port = port;
        item.dest_port = cur_watch;
        return item;
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(0, 99) < 85)
            return port_pool[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    function automatic tumc_req_t random_item();
        tumc_req_t item;
        logic [47:0] value;
        int pick;
        int span;
        int hdr;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            value = rand48();
            if ($urandom_range(0, 4) == 0)
                value[15:0] = 16'd0;
            return table_write(pick_port(), value);
        end
        if (pick >= 92)
            return noise_item();
        item = mirror_candidate(pick_port());
        item.ip_hdr_words = 4'($urandom);
        item.tcp_hdr_words = 4'($urandom);
        hdr = 4 * int'(item.ip_hdr_words) + 4 * int'(item.tcp_hdr_words);
        span = 34 + 4 * int'(item.ip_hdr_words);
        span += ($urandom_range(0, 29) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
        item.frame_len = (span > 65535) ? 16'hFFFF : 16'(span);
        case ($urandom_range(0, 9))
            0: item.ip_total_len = 16'(hdr);
            1: item.ip_total_len = 16'($urandom);
            default: item.ip_total_len = 16'(hdr + $urandom_range(1, 1460));
        endcase
        if (pick >= 75)
        begin
            case ($urandom_range(0, 6))
                0: item.pkt_mark = cur_mark;
                1: item.frame_len = 16'($urandom_range(0, 33));
                2: item.ethertype = 16'($urandom);
                3: item.ip_protocol = 8'($urandom);
                4: item.dest_port = 16'($urandom);
                5: item.frame_len = 16'(33 + 4 * int'(item.ip_hdr_words) - $urandom_range(0, 3));
                default: item.server_port = 16'($urandom);
            endcase
        end
        return item;
    endfunction

    task automatic send_item(input tumc_req_t item);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pending_results.push_back(classify_item(item));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index <= reg_index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (reg_index == CFG_MIRROR_MARK)
            cur_mark = data;
        else
            cur_watch = data[15:0];
        @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic [47:0] want, input logic [47:0] got);
        if (want !== got)
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        tumc_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp !== want)
                begin
                    fail_count++;
                    report_field("verdict", 48'(want.verdict), 48'(rsp.verdict));
                    report_field("udp_dest_port", 48'(want.udp_dest_port), 48'(rsp.udp_dest_port));
                    report_field("udp_length", 48'(want.udp_length), 48'(rsp.udp_length));
                    report_field("payload_offset", 48'(want.payload_offset),
                                 48'(rsp.payload_offset));
                    report_field("tcp_port_tag", 48'(want.tcp_port_tag), 48'(rsp.tcp_port_tag));
                    report_field("new_ip_checksum", 48'(want.new_ip_checksum),
                                 48'(rsp.new_ip_checksum));
                end
            end
        end
    end

    initial
    begin
        int hold;
        rsp_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 5);
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    task automatic test_table_load();
        send_item(table_write(16'h0000, {32'hFFFF_FFFF, 16'hFFFF}));
        send_item(table_write(16'hFFFF, {32'h0000_0000, 16'h0001}));
        send_item(table_write(16'h1234, {32'hA5A5_A5A5, 16'h0000}));
        send_item(table_write(16'h0001, {32'($urandom), 16'($urandom_range(1, 65535))}));
    endtask

    task automatic test_check_order();
        tumc_req_t item;
        item = mirror_candidate(16'h0000);
        item.pkt_mark = cur_mark;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.frame_len = 16'd0;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.frame_len = 16'd13;
        item.ethertype = 16'h86DD;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.frame_len = 16'd14;
        item.ethertype = 16'h86DD;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.frame_len = 16'd33;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.ip_protocol = 8'd17;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.frame_len = 16'd53;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.dest_port = cur_watch + 16'd1;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.ip_total_len = 16'd40;
        send_item(item);
        send_item(mirror_candidate(16'h1234));
        send_item(mirror_candidate(16'h5555));
    endtask

    task automatic test_mirror_fields();
        tumc_req_t item;
        item = mirror_candidate(16'h0000);
        item.ip_checksum = 16'h0000;
        send_item(item);
        item = mirror_candidate(16'h0000);
        item.ip_hdr_words = 4'd0;
        item.tcp_hdr_words = 4'd0;
        item.ip_total_len = 16'd1;
        item.frame_len = 16'd34;
        item.ip_checksum = 16'hFFFF;
        send_item(item);
        item = mirror_candidate(16'hFFFF);
        item.ip_hdr_words = 4'd15;
        item.tcp_hdr_words = 4'd15;
        item.ip_total_len = 16'hFFFF;
        item.frame_len = 16'hFFFF;
        item.ip_checksum = 16'h000B;
        send_item(item);
        item = mirror_candidate(16'h0001);
        item.ip_hdr_words = 4'd15;
        item.ip_total_len = 16'd10;
        item.frame_len = 16'd200;
        send_item(item);
        item = mirror_candidate(16'h0001);
        item.ip_hdr_words = 4'd7;
        item.frame_len = 16'd62;
        send_item(item);
        send_item(table_write(16'h0000, {32'h1234_5678, 16'h0000}));
        send_item(mirror_candidate(16'h0000));
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_item(random_item());
        end
        steady = 1'b0;
    endtask

    task automatic test_register_sweep();
        test_random_traffic(300);
        drain();
        write_register(CFG_MIRROR_MARK, 32'h0000_0000);
        write_register(CFG_WATCHED_PORT, 32'h0000_0000);
        test_random_traffic(300);
        drain();
        write_register(CFG_MIRROR_MARK, 32'hFFFF_FFFF);
        write_register(CFG_WATCHED_PORT, {16'($urandom), 16'hFFFF});
        test_random_traffic(300);
        drain();
        write_register(CFG_MIRROR_MARK, $urandom);
        write_register(CFG_WATCHED_PORT, $urandom);
        test_random_traffic(400);
        drain();
        write_register(CFG_WATCHED_PORT, {16'($urandom), port_pool[$urandom_range(0, 7)]});
        write_register(CFG_MIRROR_MARK, 32'(MIRROR_MARK_RST));
        test_random_traffic(400);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIRROR_MARK;
        cfg_data = '0;
        steady = 1'b0;
        fail_count = 0;
        cur_mark = MIRROR_MARK_RST;
        cur_watch = WATCHED_PORT_RST;
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            port_pool[i] = 16'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_check_order();
        test_mirror_fields();
        test_register_sweep();

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
